// File: hw/rtl/sgfa_pkg.sv
`default_nettype none
package sgfa_pkg;

  localparam int FORCE_BITS   = 36;
  localparam int MAX_PART_DEF = 1024;
  localparam int IDX_W        = 10;
  localparam int POS_W        = 24;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  // datapath widths of the serial units
  localparam int SQ_IN_W   = 50;
  localparam int ROOT_W    = 25;
  localparam int DIV_NUM_W = 62;
  localparam int DIV_DEN_W = 25;

  localparam logic [CFG_IDX_W-1:0] REG_FORCE_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY      = 2'd2;

  localparam logic KIND_SPRING = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic [IDX_W-1:0]        first_index;
    logic [IDX_W-1:0]        second_index;
    logic signed [POS_W-1:0] first_x;
    logic signed [POS_W-1:0] first_y;
    logic signed [POS_W-1:0] second_x;
    logic signed [POS_W-1:0] second_y;
    logic [POS_W-1:0]        rest_length;
    logic [POS_W-1:0]        particle_mass;
    logic                    particle_fixed;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]             particle_id;
    logic signed [FORCE_BITS-1:0] total_force_x;
    logic signed [FORCE_BITS-1:0] total_force_y;
    logic                         overflowed;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef struct packed {
    logic signed [FORCE_BITS-1:0] val;
    logic                         of;
  } sat_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SQX, S_SQY, S_SQRT, S_PROD, S_DIV1, S_SCALE,
    S_DIV2, S_RD1, S_WR1, S_RD2, S_WR2, S_RRD, S_RCLR, S_FIN
  } state_t;

  // sign-magnitude term clamped into the force range
  function automatic sat_t sat_term(logic neg, logic [DIV_NUM_W-1:0] mag);
    logic [64:0] lim;
    logic [64:0] m;
    sat_t        r;
    lim = (65'd1 << (FORCE_BITS - 1)) - (neg ? 65'd0 : 65'd1);
    m   = 65'(mag);
    r.of = 1'b0;
    if (m > lim) begin
      m    = lim;
      r.of = 1'b1;
    end
    r.val = FORCE_BITS'(neg ? (65'd0 - m) : m);
    return r;
  endfunction

  function automatic sat_t add_sat(logic signed [FORCE_BITS-1:0] a,
                                   logic signed [FORCE_BITS-1:0] b);
    logic signed [FORCE_BITS:0] s;
    sat_t r;
    s    = {a[FORCE_BITS-1], a} + {b[FORCE_BITS-1], b};
    r.of = s[FORCE_BITS] ^ s[FORCE_BITS-1];
    if (r.of) begin
      r.val = s[FORCE_BITS] ? {1'b1, {(FORCE_BITS-1){1'b0}}}
                            : {1'b0, {(FORCE_BITS-1){1'b1}}};
    end else begin
      r.val = s[FORCE_BITS-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sgfa_ram.sv
`default_nettype none
module sgfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/sgfa_sqrt.sv
`default_nettype none
// bit-serial integer square root, two radicand bits per cycle
module sgfa_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [sgfa_pkg::SQ_IN_W-1:0]  value,
  output logic [sgfa_pkg::ROOT_W-1:0]        root,
  output sgfa_pkg::unit_stat_t               stat
);
  localparam int RW = sgfa_pkg::ROOT_W;
  localparam int CW = $clog2(RW);

  logic [sgfa_pkg::SQ_IN_W-1:0] val_r;
  logic [RW+1:0]                rem_r;
  logic [RW-1:0]                root_r;
  logic [CW-1:0]                cnt_r;
  logic                         busy_r, done_r;
  logic [RW+3:0]                rem_sh;
  logic [RW+3:0]                trial;
  logic                         take;

  assign rem_sh = {rem_r, val_r[sgfa_pkg::SQ_IN_W-1 -: 2]};
  assign trial  = (RW+4)'({root_r, 2'b01});
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(RW - 1));
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CW'(RW - 1))) begin
        busy_r <= 1'b0;
      end
    end
    if (start) begin
      val_r  <= value;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      val_r  <= val_r << 2;
      rem_r  <= take ? (RW+2)'(rem_sh - trial) : (RW+2)'(rem_sh);
      root_r <= {root_r[RW-2:0], take};
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
endmodule
`default_nettype wire

// File: hw/rtl/sgfa_div.sv
`default_nettype none
// restoring unsigned divider, one quotient bit per cycle
module sgfa_div (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [sgfa_pkg::DIV_NUM_W-1:0]  dividend,
  input  wire logic [sgfa_pkg::DIV_DEN_W-1:0]  divisor,
  output logic [sgfa_pkg::DIV_NUM_W-1:0]       quotient,
  output sgfa_pkg::unit_stat_t                 stat
);
  localparam int NW = sgfa_pkg::DIV_NUM_W;
  localparam int DW = sgfa_pkg::DIV_DEN_W;
  localparam int CW = $clog2(NW);

  logic [NW-1:0] quo_r;
  logic [DW-1:0] den_r;
  logic [DW-1:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   rem_sh;
  logic          take;

  assign rem_sh = {rem_r, quo_r[NW-1]};
  assign take   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(NW - 1));
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CW'(NW - 1))) begin
        busy_r <= 1'b0;
      end
    end
    if (start) begin
      quo_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= take ? DW'(rem_sh - {1'b0, den_r}) : DW'(rem_sh);
      quo_r <= {quo_r[NW-2:0], take};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
endmodule
`default_nettype wire

// File: hw/rtl/spring_gravity_force_accumulator.sv
`default_nettype none
// 2-D mass-spring force accumulator. A spring transaction (kind 0), if enabled, adds the
// Hooke force k/L*(d-L)/d*(dx,dy) to the first particle's stored force and its negation to
// the second particle's; a read transaction (kind 1) returns the stored force plus mass*g
// on y when gravity is on and the particle is not fixed, the sticky saturation flag, and
// clears that entry. Forces are Q15.20 and saturate. After reset the force memory is swept
// clear, during which in_stall is high. A spring transaction runs a 25-step bit-serial
// square root and four 62-step divisions on one shared serial divider, then a
// read-modify-write of each endpoint through the single force memory. The result register
// lets a new transaction enter while a finished result still waits under out_stall.
module spring_gravity_force_accumulator #(
  parameter int MAX_PARTICLES = sgfa_pkg::MAX_PART_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire sgfa_pkg::in_item_t                   in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output sgfa_pkg::out_item_t                       out_data,
  input  wire logic                                 cfg_we,
  input  wire logic [sgfa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [sgfa_pkg::CFG_DATA_W-1:0]      cfg_data
);
  localparam int FB = sgfa_pkg::FORCE_BITS;
  localparam int AW = $clog2(MAX_PARTICLES);
  localparam int WW = 2 * FB + 1;
  localparam int NW = sgfa_pkg::DIV_NUM_W;
  localparam int DW = sgfa_pkg::DIV_DEN_W;
  localparam int RW = sgfa_pkg::ROOT_W;

  sgfa_pkg::state_t state_r, state_nxt;

  // configuration
  logic [1:0]         en_r;
  logic [31:0]        k_r;
  logic signed [23:0] g_r;

  // transaction registers
  sgfa_pkg::in_item_t item_r;
  logic signed [24:0] dx_r, dy_r;
  logic [49:0]        acc_r;
  logic [RW-1:0]      d_r;
  logic signed [25:0] dl_r;
  logic               axis_r;
  logic               neg_r;
  logic               fxneg_r, fyneg_r;
  logic [NW-1:0]      fxmag_r, fymag_r;
  logic [AW-1:0]      clr_r;

  // read path
  logic signed [FB-1:0] sx_r, sy_r;
  logic                 sof_r;
  logic [47:0]          gprod_r;
  logic                 gneg_r;

  sgfa_pkg::out_item_t out_r;
  logic                out_valid_r;

  // units
  logic                 sq_start, dv_start;
  logic [49:0]          sq_value;
  logic [RW-1:0]        sq_root;
  sgfa_pkg::unit_stat_t sq_stat, dv_stat;
  logic [NW-1:0]        dv_num, dv_quo;
  logic [DW-1:0]        dv_den;

  // memory
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [WW-1:0] mem_wdata, mem_rdata;

  // combinational datapath
  logic signed [49:0] sq_term;
  logic signed [50:0] dl_prod;
  logic [50:0]        dl_mag;
  logic [56:0]        k_prod;
  logic signed [RW:0] dl_new;
  logic               idx1_ok, idx2_ok;
  logic               rd_ok;
  logic               apply_neg;
  logic signed [FB-1:0] old_x, old_y;
  sgfa_pkg::sat_t     tx, ty, ax, ay;
  sgfa_pkg::sat_t     gterm, gadd;
  logic               grav_on;
  logic               out_free;

  assign idx1_ok  = 32'(item_r.first_index) < MAX_PARTICLES;
  assign idx2_ok  = 32'(item_r.second_index) < MAX_PARTICLES;
  assign out_free = !out_valid_r || !out_stall;
  assign grav_on  = en_r[0] && !item_r.particle_fixed;

  sgfa_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (sq_value),
    .root  (sq_root),
    .stat  (sq_stat)
  );

  sgfa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (dv_num),
    .divisor  (dv_den),
    .quotient (dv_quo),
    .stat     (dv_stat)
  );

  // packed entry: {overflow mark, force y, force x}
  sgfa_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_PARTICLES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // squares for the root, one per cycle
  assign sq_term  = (state_r == sgfa_pkg::S_SQX) ? dx_r * dx_r : dy_r * dy_r;
  assign sq_value = acc_r + 50'(sq_term);
  assign sq_start = (state_r == sgfa_pkg::S_SQY);

  // (d-L)*delta for the first division, q*k*16 for the second
  assign dl_prod = dl_r * (axis_r ? dy_r : dx_r);
  assign dl_mag  = dl_prod[50] ? 51'(-dl_prod) : 51'(dl_prod);
  assign k_prod  = dv_quo[RW-1:0] * k_r;
  assign dv_start = (state_r == sgfa_pkg::S_PROD) || (state_r == sgfa_pkg::S_SCALE);
  assign dv_num   = (state_r == sgfa_pkg::S_PROD) ? NW'(dl_mag) : NW'({k_prod, 4'b0000});
  assign dv_den   = (state_r == sgfa_pkg::S_PROD) ? d_r : DW'(item_r.rest_length);

  assign dl_new = $signed({1'b0, sq_root}) - $signed({2'b00, item_r.rest_length});

  // endpoint update, second endpoint gets the negated force
  assign apply_neg = (state_r == sgfa_pkg::S_WR2);
  assign old_x = mem_rdata[FB-1:0];
  assign old_y = mem_rdata[2*FB-1:FB];
  assign tx    = sgfa_pkg::sat_term(fxneg_r ^ apply_neg, fxmag_r);
  assign ty    = sgfa_pkg::sat_term(fyneg_r ^ apply_neg, fymag_r);
  assign ax    = sgfa_pkg::add_sat(old_x, tx.val);
  assign ay    = sgfa_pkg::add_sat(old_y, ty.val);

  // gravity term on a read
  assign gterm = sgfa_pkg::sat_term(gneg_r, NW'(gprod_r >> 12));
  assign gadd  = sgfa_pkg::add_sat(sy_r, gterm.val);

  assign rd_ok = idx1_ok;

  // memory ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(item_r.first_index);
    mem_wdata = '0;
    mem_raddr = AW'(item_r.first_index);
    case (state_r)
      sgfa_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
      end
      sgfa_pkg::S_RD2: begin
        mem_raddr = AW'(item_r.second_index);
      end
      sgfa_pkg::S_WR1, sgfa_pkg::S_WR2: begin
        mem_we    = 1'b1;
        mem_waddr = apply_neg ? AW'(item_r.second_index) : AW'(item_r.first_index);
        mem_wdata = {mem_rdata[2*FB] | tx.of | ty.of | ax.of | ay.of, ay.val, ax.val};
      end
      sgfa_pkg::S_RCLR: begin
        mem_we = rd_ok;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sgfa_pkg::S_CLEAR: begin
        if (32'(clr_r) == MAX_PARTICLES - 1) state_nxt = sgfa_pkg::S_IDLE;
      end
      sgfa_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_data.kind == sgfa_pkg::KIND_READ) begin
            state_nxt = sgfa_pkg::S_RRD;
          end else if (en_r[1]) begin
            state_nxt = sgfa_pkg::S_SQX;
          end
        end
      end
      sgfa_pkg::S_SQX: state_nxt = sgfa_pkg::S_SQY;
      sgfa_pkg::S_SQY: state_nxt = sgfa_pkg::S_SQRT;
      sgfa_pkg::S_SQRT: begin
        if (sq_stat.done) begin
          // zero length or zero rest length adds nothing
          if (sq_root == '0 || item_r.rest_length == '0) state_nxt = sgfa_pkg::S_IDLE;
          else state_nxt = sgfa_pkg::S_PROD;
        end
      end
      sgfa_pkg::S_PROD: state_nxt = sgfa_pkg::S_DIV1;
      sgfa_pkg::S_DIV1: begin
        if (dv_stat.done) state_nxt = sgfa_pkg::S_SCALE;
      end
      sgfa_pkg::S_SCALE: state_nxt = sgfa_pkg::S_DIV2;
      sgfa_pkg::S_DIV2: begin
        if (dv_stat.done) state_nxt = axis_r ? sgfa_pkg::S_RD1 : sgfa_pkg::S_PROD;
      end
      sgfa_pkg::S_RD1: state_nxt = idx1_ok ? sgfa_pkg::S_WR1 : sgfa_pkg::S_RD2;
      sgfa_pkg::S_WR1: state_nxt = sgfa_pkg::S_RD2;
      sgfa_pkg::S_RD2: state_nxt = idx2_ok ? sgfa_pkg::S_WR2 : sgfa_pkg::S_IDLE;
      sgfa_pkg::S_WR2: state_nxt = sgfa_pkg::S_IDLE;
      sgfa_pkg::S_RRD: state_nxt = sgfa_pkg::S_RCLR;
      sgfa_pkg::S_RCLR: state_nxt = sgfa_pkg::S_FIN;
      sgfa_pkg::S_FIN: begin
        if (out_free) state_nxt = sgfa_pkg::S_IDLE;
      end
      default: state_nxt = sgfa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sgfa_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 2'd3;
      k_r  <= '0;
      g_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sgfa_pkg::REG_FORCE_ENABLE: en_r <= cfg_data[1:0];
        sgfa_pkg::REG_STIFFNESS:    k_r  <= cfg_data;
        sgfa_pkg::REG_GRAVITY:      g_r  <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

  // clear sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (state_r == sgfa_pkg::S_CLEAR) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      sgfa_pkg::S_IDLE: begin
        if (in_valid) begin
          item_r <= in_data;
          dx_r   <= 25'(in_data.second_x) - 25'(in_data.first_x);
          dy_r   <= 25'(in_data.second_y) - 25'(in_data.first_y);
        end
      end
      sgfa_pkg::S_SQX: acc_r <= 50'(sq_term);
      sgfa_pkg::S_SQRT: begin
        d_r    <= sq_root;
        dl_r   <= 26'(dl_new);
        axis_r <= 1'b0;
      end
      sgfa_pkg::S_PROD: neg_r <= dl_prod[50];
      sgfa_pkg::S_DIV2: begin
        if (dv_stat.done) begin
          if (axis_r) begin
            fyneg_r <= neg_r;
            fymag_r <= dv_quo;
          end else begin
            fxneg_r <= neg_r;
            fxmag_r <= dv_quo;
          end
          axis_r <= 1'b1;
        end
      end
      sgfa_pkg::S_RRD: begin
        gneg_r  <= g_r[23];
        gprod_r <= (g_r[23] ? 24'(-g_r) : 24'(g_r)) * item_r.particle_mass;
      end
      sgfa_pkg::S_RCLR: begin
        // out-of-range read sees an empty entry
        sx_r  <= rd_ok ? $signed(mem_rdata[FB-1:0]) : '0;
        sy_r  <= rd_ok ? $signed(mem_rdata[2*FB-1:FB]) : '0;
        sof_r <= rd_ok ? mem_rdata[2*FB] : 1'b0;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (state_r == sgfa_pkg::S_FIN && out_free) out_valid_r <= 1'b1;
    end
    if (state_r == sgfa_pkg::S_FIN && out_free) begin
      out_r.particle_id   <= item_r.first_index;
      out_r.total_force_x <= sx_r;
      out_r.total_force_y <= grav_on ? gadd.val : sy_r;
      out_r.overflowed    <= sof_r | (grav_on & (gterm.of | gadd.of));
    end
  end

  assign in_stall  = (state_r != sgfa_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

// File: dv/tb_spring_gravity_force_accumulator.sv
`default_nettype none

// scoreboard: keeps its own copy of the force store and the registers, and
// queues the totals that read transactions are due to return
class force_ledger;
  localparam int DEPTH = 1024;
  localparam longint FMAX = (64'sd1 <<< (sgfa_pkg::FORCE_BITS - 1)) - 1;
  localparam longint FMIN = -FMAX - 1;

  longint              sum_x[DEPTH];
  longint              sum_y[DEPTH];
  bit                  sat_mark[DEPTH];
  bit [1:0]            enables;
  longint unsigned     stiffness;
  longint              gravity;
  sgfa_pkg::out_item_t pending_totals[$];
  int                  errors;
  int                  reads_seen;
  int                  springs_seen;
  int                  saturations;

  function void clear_all();
    foreach (sum_x[i]) begin
      sum_x[i]    = 0;
      sum_y[i]    = 0;
      sat_mark[i] = 1'b0;
    end
    enables   = 2'd3;
    stiffness = 0;
    gravity   = 0;
    errors    = 0;
  endfunction

  function void set_reg(logic [sgfa_pkg::CFG_IDX_W-1:0] idx,
                        logic [sgfa_pkg::CFG_DATA_W-1:0] value);
    case (idx)
      sgfa_pkg::REG_FORCE_ENABLE: enables = value[1:0];
      sgfa_pkg::REG_STIFFNESS:    stiffness = 64'(value);
      sgfa_pkg::REG_GRAVITY:      gravity = longint'($signed(value[23:0]));
      default: ;
    endcase
  endfunction

  function longint unsigned int_root(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // (num * mul) / den, rounded toward zero
  function longint scale_div(longint num, longint unsigned mul, longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? longint'(-num) : num;
    q = (mag * mul) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function longint clamp(longint v, inout bit sat);
    if (v > FMAX) begin
      sat = 1'b1;
      return FMAX;
    end
    if (v < FMIN) begin
      sat = 1'b1;
      return FMIN;
    end
    return v;
  endfunction

  function longint sat_add(longint s, longint d, inout bit sat);
    return clamp(s + d, sat);
  endfunction

  function void add_force(int idx, longint fx, longint fy);
    bit sat;
    sat = 1'b0;
    fx = clamp(fx, sat);
    fy = clamp(fy, sat);
    sum_x[idx] = sat_add(sum_x[idx], fx, sat);
    sum_y[idx] = sat_add(sum_y[idx], fy, sat);
    if (sat) begin
      sat_mark[idx] = 1'b1;
      saturations++;
    end
  endfunction

  // note an accepted input transaction
  function void accept(sgfa_pkg::in_item_t it);
    longint              dx, dy, dl, qx, qy, fx, fy, grav;
    longint unsigned     sep, rest;
    sgfa_pkg::out_item_t tot;
    longint              sy;
    bit                  sat;
    if (it.kind == sgfa_pkg::KIND_SPRING) begin
      if (!enables[1]) return;
      springs_seen++;
      dx   = longint'(it.second_x) - longint'(it.first_x);
      dy   = longint'(it.second_y) - longint'(it.first_y);
      sep  = int_root(longint'(dx * dx) + longint'(dy * dy));
      rest = 64'(it.rest_length);
      if (sep == 0 || rest == 0) return;
      dl = longint'(sep) - longint'(rest);
      qx = scale_div(dl * dx, 64'd1, sep);
      qy = scale_div(dl * dy, 64'd1, sep);
      fx = scale_div(qx, stiffness * 64'd16, rest);
      fy = scale_div(qy, stiffness * 64'd16, rest);
      add_force(int'(it.first_index), fx, fy);
      add_force(int'(it.second_index), -fx, -fy);
    end else begin
      reads_seen++;
      tot.particle_id   = it.first_index;
      tot.total_force_x = 36'(sum_x[it.first_index]);
      sy  = sum_y[it.first_index];
      sat = sat_mark[it.first_index];
      sum_x[it.first_index]    = 0;
      sum_y[it.first_index]    = 0;
      sat_mark[it.first_index] = 1'b0;
      if (enables[0] && !it.particle_fixed) begin
        grav = scale_div(gravity, 64'(it.particle_mass), 64'd4096);
        grav = clamp(grav, sat);
        sy   = sat_add(sy, grav, sat);
      end
      tot.total_force_y = 36'(sy);
      tot.overflowed    = sat;
      pending_totals = {pending_totals, tot};
    end
  endfunction

  // compare a returned total with the oldest one due
  function void check_total(sgfa_pkg::out_item_t got);
    sgfa_pkg::out_item_t want;
    if (pending_totals.size() == 0) begin
      $error("unexpected result for particle %0d", got.particle_id);
      errors++;
      return;
    end
    want = pending_totals.pop_front();
    if (got.particle_id !== want.particle_id) begin
      $error("particle_id expected %0d got %0d", want.particle_id, got.particle_id);
      errors++;
    end
    if (got.total_force_x !== want.total_force_x) begin
      $error("total_force_x expected %0d got %0d", want.total_force_x, got.total_force_x);
      errors++;
    end
    if (got.total_force_y !== want.total_force_y) begin
      $error("total_force_y expected %0d got %0d", want.total_force_y, got.total_force_y);
      errors++;
    end
    if (got.overflowed !== want.overflowed) begin
      $error("overflowed expected %0d got %0d", want.overflowed, got.overflowed);
      errors++;
    end
  endfunction
endclass

module tb_spring_gravity_force_accumulator;

  localparam int DRAIN_CYCLES = 400;   // long enough for a last spring transaction to finish
  localparam int HANG_LIMIT   = 8000;  // covers the clearing sweep after reset

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  sgfa_pkg::in_item_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  sgfa_pkg::out_item_t             out_data;
  logic                            cfg_we    = 1'b0;
  logic [sgfa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sgfa_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  force_ledger ledger;
  int          send_idle_pct;   // chance per transaction that the sender idles
  int          stall_pct;       // chance per cycle that the receiver stalls
  int          quiet_cycles;

  spring_gravity_force_accumulator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // result side: check accepted results, randomize stall, watch for a hang
  always @(posedge clk) begin
    if (out_valid && !out_stall) ledger.check_total(out_data);
    if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    out_stall <= ($urandom_range(99) < stall_pct);
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles", HANG_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(logic [sgfa_pkg::CFG_IDX_W-1:0] idx,
                           logic [sgfa_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ledger.set_reg(idx, value);
  endtask

  // valid is only ever assigned once per time step: either lowered for an idle
  // stretch or raised for the next transaction
  task automatic send(sgfa_pkg::in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    ledger.accept(it);
  endtask

  // hold off until every read has returned, then let a last spring finish
  task automatic drain();
    in_valid <= 1'b0;
    while (ledger.pending_totals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic sgfa_pkg::in_item_t spring(int a, int b, int ax, int ay, int bx, int by,
                                                int len);
    sgfa_pkg::in_item_t it;
    it = '0;
    it.kind         = sgfa_pkg::KIND_SPRING;
    it.first_index  = 10'(a);
    it.second_index = 10'(b);
    it.first_x      = 24'(ax);
    it.first_y      = 24'(ay);
    it.second_x     = 24'(bx);
    it.second_y     = 24'(by);
    it.rest_length  = 24'(len);
    return it;
  endfunction

  function automatic sgfa_pkg::in_item_t read_of(int idx, int mass, bit pinned);
    sgfa_pkg::in_item_t it;
    it = '0;
    it.kind           = sgfa_pkg::KIND_READ;
    it.first_index    = 10'(idx);
    it.particle_mass  = 24'(mass);
    it.particle_fixed = pinned;
    return it;
  endfunction

  // random transaction: mostly a small pool of particles so forces pile up
  // before being read back, positions either anywhere or close together
  function automatic sgfa_pkg::in_item_t random_item();
    sgfa_pkg::in_item_t it;
    int                 span;
    it = sgfa_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                               6'($urandom)});
    if ($urandom_range(99) < 85) begin
      it.first_index  = 10'($urandom_range(15));
      it.second_index = 10'($urandom_range(15));
    end
    it.kind = ($urandom_range(99) < 40) ? sgfa_pkg::KIND_READ : sgfa_pkg::KIND_SPRING;
    if ($urandom_range(1)) begin
      span = 1 << $urandom_range(4, 20);
      it.second_x = 24'(int'(it.first_x) + int'($urandom_range(2 * span)) - span);
      it.second_y = 24'(int'(it.first_y) + int'($urandom_range(2 * span)) - span);
    end
    case ($urandom_range(5))
      0: it.rest_length = 24'($urandom_range(255));
      1: it.rest_length = '0;
      2: it.rest_length = 24'($urandom_range(1 << 20));
      default: ;
    endcase
    return it;
  endfunction

  task automatic run_phase(int fe, int unsigned k, int g, int idle, int stall, int count);
    write_reg(sgfa_pkg::REG_FORCE_ENABLE, fe);
    write_reg(sgfa_pkg::REG_STIFFNESS, k);
    write_reg(sgfa_pkg::REG_GRAVITY, g & 32'h00ff_ffff);
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (count) send(random_item());
    drain();
  endtask

  initial begin
    ledger = new();
    ledger.clear_all();
    send_idle_pct = 0;
    stall_pct     = 0;
    quiet_cycles  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: unit stiffness, earth-like gravity, both forces on
    write_reg(sgfa_pkg::REG_FORCE_ENABLE, 3);
    write_reg(sgfa_pkg::REG_STIFFNESS, 32'h0001_0000);
    write_reg(sgfa_pkg::REG_GRAVITY, -24'sd642253 & 32'h00ff_ffff);
    send(spring(0, 1, -8388608, -8388608, 8388607, 8388607, 1));        // corner to corner
    send(spring(2, 3, 8388607, -8388608, -8388608, 8388607, 16777215)); // longest rest
    send(spring(4, 5, 1000, 2000, 1000, 2000, 4096));                   // zero length
    send(spring(4, 5, 0, 0, 300000, -400000, 0));                       // zero rest
    send(spring(6, 6, 0, 0, 1 << 20, 0, 1 << 19));                      // same endpoints
    send(spring(1023, 7, 5, 7, -3, 11, 2));
    send(read_of(0, 16777215, 1'b0));
    send(read_of(1, 0, 1'b0));
    send(read_of(2, 1 << 16, 1'b1));                                    // pinned
    send(read_of(3, 1 << 16, 1'b0));
    send(read_of(4, 12345, 1'b0));
    send(read_of(6, 1 << 16, 1'b0));
    send(read_of(1023, 16777215, 1'b0));
    send(read_of(7, 16777215, 1'b1));
    drain();
    // maximum stiffness and gravity to force saturation
    write_reg(sgfa_pkg::REG_STIFFNESS, 32'hffff_ffff);
    write_reg(sgfa_pkg::REG_GRAVITY, 32'h007f_ffff);
    send(spring(8, 9, -8388608, 0, 8388607, 0, 1));
    send(spring(8, 9, -8388608, 0, 8388607, 0, 1));
    send(read_of(8, 16777215, 1'b0));
    send(read_of(9, 16777215, 1'b0));
    drain();
    write_reg(sgfa_pkg::REG_GRAVITY, 32'h0080_0000);
    send(read_of(10, 16777215, 1'b0));
    drain();
    // springs off, gravity off
    write_reg(sgfa_pkg::REG_FORCE_ENABLE, 0);
    send(spring(11, 12, 0, 0, 5000, 5000, 10));
    send(read_of(11, 16777215, 1'b0));
    drain();

    // random phases: register settings and handshake pressure vary together
    run_phase(3, 32'h0001_0000, -642253,   0,  0, 275);
    run_phase(3, 32'hffff_ffff, 8388607,  60,  0, 275);
    run_phase(2, $urandom,      $urandom,  0, 60, 275);
    run_phase(1, $urandom,      -8388608, 15, 15, 275);
    run_phase(3, $urandom_range(255), $urandom, 60, 60, 275);
    run_phase(0, 0,             0,        15, 15, 275);

    $display("covered %0d spring and %0d read transactions, %0d saturating updates",
             ledger.springs_seen, ledger.reads_seen, ledger.saturations);
    $display("register settings from zero to full scale under several idle and stall mixes");
    if (ledger.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
